FILE: hdl/ttt_pkg.sv
// Shared types, codes and sizes for the transaction tag tracker.
`timescale 1ns / 1ps

package ttt_pkg;

    // Field widths
    localparam int OPCODE_W     = 2;
    localparam int OWNER_W      = 8;
    localparam int TAG_W        = 8;
    localparam int STATUS_W     = 8;
    localparam int CODE_W       = 3;
    localparam int DEF_NUM_TAGS = 256;

    // Request opcodes
    localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POST    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_ABANDON = 2'd2;

    // Result codes
    localparam logic [CODE_W-1:0] CODE_OK      = 3'd0;
    localparam logic [CODE_W-1:0] CODE_IGNORED = 3'd1;
    localparam logic [CODE_W-1:0] CODE_INVALID = 3'd2;
    localparam logic [CODE_W-1:0] CODE_LATE    = 3'd3;
    localparam logic [CODE_W-1:0] CODE_STALE   = 3'd4;
    localparam logic [CODE_W-1:0] CODE_FULL    = 3'd5;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        DP_NONE,
        DP_LOAD,
        DP_ALLOC_STEP,
        DP_POST_RD,
        DP_POST_FIN,
        DP_ABN_RD,
        DP_ABN_CHK,
        DP_IGNORE
    } t_dp_op;

    // Controller to datapath
    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic alloc_done;
        logic abn_done;
        logic out_free;
    } t_sts;

endpackage

FILE: hdl/transaction_tag_tracker.sv
// Sequence, accept to o_valid: allocate tests tags in turn from the search pointer, up to NUM_TAGS of them;
// post does one registered owner memory read and a check; unused opcode 3 is ignored; abandon scans up to
// NUM_TAGS tags, since each tag in the scan needs a registered owner memory read and a compare.
// Throughput: one request at a time; the next is accepted in the cycle after the result loads,
// even while that result waits; a result only holds the engine while the output register is full.
// Reset: synchronous; in-use and ownership bits, search pointer and control clear.
`timescale 1ns / 1ps

module transaction_tag_tracker
    import ttt_pkg::*;
#(
    parameter int NUM_TAGS = DEF_NUM_TAGS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [OWNER_W-1:0]  i_owner,
    input  logic [TAG_W-1:0]    i_tag,
    input  logic [STATUS_W-1:0] i_status_value,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CODE_W-1:0]   o_code,
    output logic [TAG_W-1:0]    o_out_tag,
    output logic [OWNER_W-1:0]  o_out_owner,
    output logic [STATUS_W-1:0] o_out_status
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    ttt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .i_sts    (w_sts),
        .o_ready  (o_ready),
        .o_cmd    (w_cmd)
    );

    // Table and result path
    ttt_datapath #(
        .NUM_TAGS (NUM_TAGS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_opcode       (i_opcode),
        .i_owner        (i_owner),
        .i_tag          (i_tag),
        .i_status_value (i_status_value),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_code         (o_code),
        .o_out_tag      (o_out_tag),
        .o_out_owner    (o_out_owner),
        .o_out_status   (o_out_status)
    );

endmodule

FILE: hdl/ttt_ctrl.sv
// Sequencing state machine of the transaction tag tracker.
`timescale 1ns / 1ps

module ttt_ctrl
    import ttt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  t_sts                i_sts,
    output logic                o_ready,
    output t_cmd                o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_POST_RD,
        S_POST_CHK,
        S_ABN_RD,
        S_ABN_CHK,
        S_IGNORE,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;

    logic w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    // Pick the command and the next state
    always_comb begin
        n_state         = r_state;
        o_cmd.op        = DP_NONE;
        o_cmd.out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.op = DP_LOAD;
                    unique case (i_opcode)
                        OP_ALLOC:   n_state = S_ALLOC;
                        OP_POST:    n_state = S_POST_RD;
                        OP_ABANDON: n_state = S_ABN_RD;
                        default:    n_state = S_IGNORE;
                    endcase
                end
            end
            S_ALLOC: begin
                o_cmd.op = DP_ALLOC_STEP;
                if (i_sts.alloc_done) begin
                    n_state = S_RESULT;
                end
            end
            S_POST_RD: begin
                o_cmd.op = DP_POST_RD;
                n_state  = S_POST_CHK;
            end
            S_POST_CHK: begin
                o_cmd.op = DP_POST_FIN;
                n_state  = S_RESULT;
            end
            S_ABN_RD: begin
                o_cmd.op = DP_ABN_RD;
                n_state  = S_ABN_CHK;
            end
            S_ABN_CHK: begin
                o_cmd.op = DP_ABN_CHK;
                n_state  = i_sts.abn_done ? S_RESULT : S_ABN_RD;
            end
            S_IGNORE: begin
                o_cmd.op = DP_IGNORE;
                n_state  = S_RESULT;
            end
            S_RESULT: begin
                // Hand the staged result over once the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/ttt_datapath.sv
// Tag table, owner memory, scan pointer and result registers.
`timescale 1ns / 1ps

module ttt_datapath
    import ttt_pkg::*;
#(
    parameter int NUM_TAGS = DEF_NUM_TAGS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [OWNER_W-1:0]  i_owner,
    input  logic [TAG_W-1:0]    i_tag,
    input  logic [STATUS_W-1:0] i_status_value,
    input  logic                i_ready,
    output logic                o_valid,
    output logic [CODE_W-1:0]   o_code,
    output logic [TAG_W-1:0]    o_out_tag,
    output logic [OWNER_W-1:0]  o_out_owner,
    output logic [STATUS_W-1:0] o_out_status
);

    localparam int IW = $clog2(NUM_TAGS);
    localparam logic [IW-1:0]  LAST_IDX     = IW'(NUM_TAGS - 1);
    localparam logic [TAG_W:0] NUM_TAGS_EXT = (TAG_W + 1)'(NUM_TAGS);

    // Tag table state
    logic [NUM_TAGS-1:0] r_in_use;
    logic [NUM_TAGS-1:0] r_has_owner;
    logic [IW-1:0]       r_next_search;
    logic [OWNER_W-1:0]  r_owner_mem [NUM_TAGS];
    logic [OWNER_W-1:0]  r_rd_data;

    // Captured request and scan position
    logic [OWNER_W-1:0]  r_owner;
    logic [TAG_W-1:0]    r_tag;
    logic [STATUS_W-1:0] r_status;
    logic [IW-1:0]       r_ptr;
    logic [IW-1:0]       r_cnt;

    // Staged and output results
    logic [CODE_W-1:0]   r_res_code;
    logic [TAG_W-1:0]    r_res_tag;
    logic [OWNER_W-1:0]  r_res_owner;
    logic [STATUS_W-1:0] r_res_status;
    logic                r_o_valid;
    logic [CODE_W-1:0]   r_out_code;
    logic [TAG_W-1:0]    r_out_tag;
    logic [OWNER_W-1:0]  r_out_owner;
    logic [STATUS_W-1:0] r_out_status;

    logic          w_alloc_hit;
    logic          w_ptr_last;
    logic [IW-1:0] w_ptr_inc;
    logic [IW-1:0] w_tag_idx;
    logic          w_tag_in_range;
    logic          w_post_live;
    logic          w_abn_match;
    logic          w_ptr_is_tag;
    logic          w_mem_we;
    logic          w_mem_re;
    logic [IW-1:0] w_mem_raddr;

    // Decode the current scan position and request
    assign w_ptr_last     = (r_cnt == LAST_IDX);
    assign w_ptr_inc      = (r_ptr == LAST_IDX) ? '0 : r_ptr + IW'(1);
    assign w_alloc_hit    = (r_ptr != '0) && !r_in_use[r_ptr];
    assign w_tag_idx      = r_tag[IW-1:0];
    assign w_tag_in_range = ({1'b0, r_tag} < NUM_TAGS_EXT);
    assign w_post_live    = w_tag_in_range && r_in_use[w_tag_idx];
    assign w_abn_match    = r_in_use[r_ptr] && r_has_owner[r_ptr] && (r_rd_data == r_owner);
    assign w_ptr_is_tag   = (TAG_W'(r_ptr) == r_tag);

    assign w_mem_we    = (i_cmd.op == DP_ALLOC_STEP) && w_alloc_hit;
    assign w_mem_re    = (i_cmd.op == DP_POST_RD) || (i_cmd.op == DP_ABN_RD);
    assign w_mem_raddr = (i_cmd.op == DP_POST_RD) ? w_tag_idx : r_ptr;

    assign o_sts.alloc_done = w_alloc_hit || w_ptr_last;
    assign o_sts.abn_done   = w_abn_match || w_ptr_last;
    assign o_sts.out_free   = !r_o_valid || i_ready;

    // Owner memory: one write and one registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_owner_mem[r_ptr] <= r_owner;
        end
        if (w_mem_re) begin
            r_rd_data <= r_owner_mem[w_mem_raddr];
        end
    end

    // Update in-use and ownership bits and the search pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use      <= '0;
            r_has_owner   <= '0;
            r_next_search <= '0;
        end else begin
            case (i_cmd.op)
                DP_ALLOC_STEP: begin
                    if (w_alloc_hit) begin
                        r_in_use[r_ptr]    <= 1'b1;
                        r_has_owner[r_ptr] <= 1'b1;
                        r_next_search      <= w_ptr_inc;
                    end
                end
                DP_POST_FIN: begin
                    if (r_tag != '0 && w_post_live) begin
                        r_in_use[w_tag_idx] <= 1'b0;
                    end
                end
                DP_ABN_CHK: begin
                    if (w_abn_match && w_ptr_is_tag) begin
                        r_has_owner[r_ptr] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Capture the request, advance the scan and stage the result
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_owner  <= i_owner;
                r_tag    <= i_tag;
                r_status <= i_status_value;
                r_cnt    <= '0;
                r_ptr    <= (i_opcode == OP_ALLOC) ? r_next_search : '0;
            end
            DP_ALLOC_STEP: begin
                r_res_owner  <= '0;
                r_res_status <= '0;
                if (w_alloc_hit) begin
                    r_res_code <= CODE_OK;
                    r_res_tag  <= TAG_W'(r_ptr);
                end else if (w_ptr_last) begin
                    r_res_code <= CODE_FULL;
                    r_res_tag  <= '0;
                end else begin
                    r_ptr <= w_ptr_inc;
                    r_cnt <= r_cnt + IW'(1);
                end
            end
            DP_POST_FIN: begin
                r_res_owner  <= '0;
                r_res_status <= '0;
                if (r_tag == '0) begin
                    r_res_code <= CODE_IGNORED;
                    r_res_tag  <= '0;
                end else if (!w_post_live) begin
                    r_res_code <= CODE_INVALID;
                    r_res_tag  <= r_tag;
                end else if (!r_has_owner[w_tag_idx]) begin
                    r_res_code <= CODE_LATE;
                    r_res_tag  <= r_tag;
                end else begin
                    r_res_code   <= CODE_OK;
                    r_res_tag    <= r_tag;
                    r_res_owner  <= r_rd_data;
                    r_res_status <= r_status;
                end
            end
            DP_ABN_CHK: begin
                r_res_owner  <= '0;
                r_res_status <= '0;
                if (w_abn_match) begin
                    r_res_code <= w_ptr_is_tag ? CODE_OK : CODE_STALE;
                    r_res_tag  <= TAG_W'(r_ptr);
                end else if (w_ptr_last) begin
                    r_res_code <= CODE_INVALID;
                    r_res_tag  <= '0;
                end else begin
                    r_ptr <= w_ptr_inc;
                    r_cnt <= r_cnt + IW'(1);
                end
            end
            DP_IGNORE: begin
                r_res_code   <= CODE_IGNORED;
                r_res_tag    <= '0;
                r_res_owner  <= '0;
                r_res_status <= '0;
            end
            default: ;
        endcase
    end

    // Output register data
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_code   <= r_res_code;
            r_out_tag    <= r_res_tag;
            r_out_owner  <= r_res_owner;
            r_out_status <= r_res_status;
        end
    end

    // Output valid: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_code       = r_out_code;
    assign o_out_tag    = r_out_tag;
    assign o_out_owner  = r_out_owner;
    assign o_out_status = r_out_status;

endmodule

FILE: hdl/ttt_checker.sv
// Port-level assertions for the transaction tag tracker and their bind.
`timescale 1ns / 1ps

module ttt_checker
    import ttt_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic [OPCODE_W-1:0] i_opcode,
    input logic [OWNER_W-1:0]  i_owner,
    input logic [TAG_W-1:0]    i_tag,
    input logic [STATUS_W-1:0] i_status_value,
    input logic                o_valid,
    input logic                i_ready,
    input logic [CODE_W-1:0]   o_code,
    input logic [TAG_W-1:0]    o_out_tag,
    input logic [OWNER_W-1:0]  o_out_owner,
    input logic [STATUS_W-1:0] o_out_status
);

    // One request at a time: ready drops after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready stayed high after a request was accepted");

    // A waiting request holds
    a_request_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_ready) |=> (i_valid && $stable(i_opcode) && $stable(i_owner)
                                   && $stable(i_tag) && $stable(i_status_value)))
        else $error("waiting request changed or dropped");

    // A stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_code) && $stable(o_out_tag)
                                   && $stable(o_out_owner) && $stable(o_out_status)))
        else $error("stalled result changed or dropped");

    // Only a delivered post carries owner and status
    a_owner_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_code != CODE_OK) |-> (o_out_owner == '0 && o_out_status == '0))
        else $error("owner or status on a result that is not ok");

    // Full and ignored results name no tag
    a_no_tag_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_code == CODE_FULL || o_code == CODE_IGNORED)) |-> (o_out_tag == '0))
        else $error("tag reported with a full or ignored result");

endmodule

bind transaction_tag_tracker ttt_checker u_ttt_checker (.*);
